>>> hw/rtl/slpq_pkg.sv
// shared types and constants for the sorted list priority queue
// no dependencies
`timescale 1ns / 1ps

package slpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int ACTION_W     = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP_FIRST = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_LAST  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ_MID  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TRAVERSE  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
    logic                      last;
    logic [COUNT_OUT_W-1:0]    entry_count;
  } out_item_t;

endpackage

>>> hw/rtl/sorted_list_priority_queue.sv
// top level of the sorted list priority queue: control sequencer around one entry ram
// depends on slpq_pkg and slpq_ram
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit values in ascending order in a single ram used as a
// ring (a head pointer makes remove first cheap). An action is taken when start is high
// and busy is low; busy then stays high up to the cycle in which the action's last result
// beat is on the outputs. Results come out as one-cycle beats marked by out_valid and must
// be taken as they appear. Per action, with the single read port of the entry ram walking
// one entry per cycle: ordered insert walks down from the tail, moving each entry not
// below the new value up one place, then writes the new value; remove first, remove last
// and read middle read one entry; traverse reads from the head, one beat per cycle; full
// and empty replies finish in the accept cycle with the beat in the following cycle and
// busy never rising; unknown actions are dropped in the accept cycle with no beat at all.
// No clearing pass is needed after reset: only entries below the count are ever read.

module sorted_list_priority_queue
  import slpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_ONE,
    S_TRAV
  } state_t;

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  // ram port signals
  logic               ram_we;
  logic [AW-1:0]      ram_wr_addr;
  logic [VALUE_W-1:0] ram_wr_data;
  logic               ram_re;
  logic [AW-1:0]      ram_rd_addr;
  logic [VALUE_W-1:0] ram_rd_data;
  logic               trav_last;

  // logical position to ring address, head + k wrapped once
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, head} + (AW+1)'(k);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic out_item_t make_out(input logic [VALUE_W-1:0] val,
                                         input logic [STATUS_W-1:0] st,
                                         input logic lst,
                                         input logic [CW-1:0] cnt);
    out_item_t o;
    o.result_value = val;
    o.status       = st;
    o.last         = lst;
    o.entry_count  = COUNT_OUT_W'(cnt);
    return o;
  endfunction

  slpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign trav_last = (idx_r == count_r - CW'(1));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wr_addr   = '0;
    ram_wr_data   = value_r;
    ram_re        = 1'b0;
    ram_rd_addr   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          value_nxt = in_data.value;
          case (in_data.action)
            ACT_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out('0, ST_FULL, 1'b1, count_r);
              end else if (count_r == '0) begin
                // empty list: drop straight into the slot at the head
                idx_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                // walk down from the tail, shifting larger-or-equal entries up
                ram_re      = 1'b1;
                ram_rd_addr = phys(head_r, count_r - CW'(1));
                idx_nxt     = count_r - CW'(1);
                state_nxt   = S_INS;
              end
            end
            ACT_POP_FIRST: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out('0, ST_EMPTY, 1'b1, count_r);
              end else begin
                ram_re      = 1'b1;
                ram_rd_addr = head_r;
                head_nxt    = phys(head_r, CW'(1));
                count_nxt   = count_r - CW'(1);
                state_nxt   = S_ONE;
              end
            end
            ACT_POP_LAST: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out('0, ST_EMPTY, 1'b1, count_r);
              end else begin
                ram_re      = 1'b1;
                ram_rd_addr = phys(head_r, count_r - CW'(1));
                count_nxt   = count_r - CW'(1);
                state_nxt   = S_ONE;
              end
            end
            ACT_READ_MID: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out('0, ST_EMPTY, 1'b1, count_r);
              end else begin
                ram_re      = 1'b1;
                ram_rd_addr = phys(head_r, (count_r - CW'(1)) >> 1);
                state_nxt   = S_ONE;
              end
            end
            ACT_TRAVERSE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = make_out('0, ST_EMPTY, 1'b1, count_r);
              end else begin
                ram_re      = 1'b1;
                ram_rd_addr = head_r;
                idx_nxt     = '0;
                state_nxt   = S_TRAV;
              end
            end
            default: begin
              // unknown action, nothing to do
            end
          endcase
        end
      end

      S_INS: begin
        ram_we = 1'b1;
        if ($signed(ram_rd_data) >= value_r) begin
          // entry moves up one place, new value goes in front of equals
          ram_wr_addr = phys(head_r, idx_r + CW'(1));
          ram_wr_data = ram_rd_data;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt     = idx_r - CW'(1);
            ram_re      = 1'b1;
            ram_rd_addr = phys(head_r, idx_r - CW'(1));
          end
        end else begin
          ram_wr_addr   = phys(head_r, idx_r + CW'(1));
          ram_wr_data   = value_r;
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = make_out('0, ST_OK, 1'b1, count_r + CW'(1));
          state_nxt     = S_IDLE;
        end
      end

      S_PUT: begin
        ram_we        = 1'b1;
        ram_wr_addr   = phys(head_r, idx_r);
        ram_wr_data   = value_r;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_data_nxt  = make_out('0, ST_OK, 1'b1, count_r + CW'(1));
        state_nxt     = S_IDLE;
      end

      S_ONE: begin
        // count already holds its post-action value
        out_valid_nxt = 1'b1;
        out_data_nxt  = make_out(ram_rd_data, ST_OK, 1'b1, count_r);
        state_nxt     = S_IDLE;
      end

      S_TRAV: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = make_out(ram_rd_data, ST_OK, trav_last, count_r);
        if (trav_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt     = idx_r + CW'(1);
          ram_re      = 1'b1;
          ram_rd_addr = phys(head_r, idx_r + CW'(1));
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // never more entries than the ram holds
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an insert into a full list is answered with a full beat next cycle
  a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_INSERT && count_r == CW'(CAPACITY))
    |=> (out_valid && out_data.status == ST_FULL && out_data.last))
    else $error("missing full reply");

  // a successful remove first drops the count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_POP_FIRST && count_r != '0)
    |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove first did not shrink the list");

  // only a traverse produces beats that are not the final one
  a_last_only_trav: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (state_r == S_TRAV))
    else $error("non-final beat outside a traverse");

  // the ram is only written while an insert is in progress
  a_write_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INS || state_r == S_PUT))
    else $error("unexpected ram write");

endmodule

>>> hw/rtl/slpq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module slpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
